/* hdl/generator_mains_transfer_sequencer_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the transfer sequencer
// Shared forms of the concurrent checks used by the top level.
// ----------------------------------------------------------------------------
`ifndef GENERATOR_MAINS_TRANSFER_SEQUENCER_CORE_ASSERT_SVH
`define GENERATOR_MAINS_TRANSFER_SEQUENCER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GMTS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GMTS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/gmts_pkg.sv */
// ----------------------------------------------------------------------------
// Transfer sequencer package
// Types, codes, reset values and the phase transition function.
// ----------------------------------------------------------------------------
package gmts_pkg;

   typedef enum logic [2:0] {
      PH_IDLE      = 3'd0,
      PH_START_DLY = 3'd1,
      PH_CRANK     = 3'd2,
      PH_CONT_DLY  = 3'd3,
      PH_STOP_DLY  = 3'd4,
      PH_SOLENOID  = 3'd5,
      PH_FIXED     = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      SQ_POWERUP = 2'd0,
      SQ_START   = 2'd1,
      SQ_STOP    = 2'd2,
      SQ_EMERG   = 2'd3
   } seq_type;

   localparam logic [2:0] FUNC_TICK    = 3'd0;
   localparam logic [2:0] FUNC_POWERUP = 3'd1;
   localparam logic [2:0] FUNC_START   = 3'd2;
   localparam logic [2:0] FUNC_STOP    = 3'd3;
   localparam logic [2:0] FUNC_EMERG   = 3'd4;

   localparam logic [2:0] REG_START_DELAY     = 3'd0;
   localparam logic [2:0] REG_STOP_DELAY      = 3'd1;
   localparam logic [2:0] REG_CRANK_TIME      = 3'd2;
   localparam logic [2:0] REG_SOLENOID_TIME   = 3'd3;
   localparam logic [2:0] REG_CONTACTOR_DELAY = 3'd4;

   localparam logic [7:0] RST_START_DELAY     = 8'd10;
   localparam logic [7:0] RST_STOP_DELAY      = 8'd10;
   localparam logic [7:0] RST_CRANK_TIME      = 8'd3;
   localparam logic [7:0] RST_SOLENOID_TIME   = 8'd5;
   localparam logic [7:0] RST_CONTACTOR_DELAY = 8'd3;

   localparam int unsigned RL_START = 0;
   localparam int unsigned RL_STOP  = 1;
   localparam int unsigned RL_GEN   = 2;
   localparam int unsigned RL_MAINS = 3;

   // The longest chain of zero-length phases is three transitions.
   localparam int unsigned SETTLE_STEPS = 4;

   typedef struct packed {
      logic [7:0] start_delay;
      logic [7:0] stop_delay;
      logic [7:0] crank_time;
      logic [7:0] solenoid_time;
      logic [7:0] contactor_delay;
   } cfg_type;

   typedef struct packed {
      phase_type  phase;
      seq_type    seq;
      logic [7:0] count;
      logic [3:0] relays;
   } state_type;

   function automatic state_type settle_step(state_type st, cfg_type cfg, logic mon);
      state_type nx;
      nx = st;
      if (st.phase != PH_IDLE && st.count == 8'd0) begin
         nx.count = 8'd0;
         case (st.phase)
            PH_START_DLY: begin
               if (mon) begin
                  nx.relays[RL_START] = 1'b1;
                  nx.phase = PH_CRANK;
                  nx.count = cfg.crank_time;
               end else begin
                  nx.phase = PH_IDLE;
               end
            end
            PH_CRANK: begin
               nx.relays[RL_START] = 1'b0;
               nx.relays[RL_GEN] = 1'b0;
               nx.relays[RL_MAINS] = 1'b0;
               nx.phase = PH_CONT_DLY;
               nx.count = cfg.contactor_delay;
            end
            PH_CONT_DLY: begin
               if (st.seq == SQ_START) begin
                  nx.relays[RL_GEN] = 1'b1;
               end else begin
                  nx.relays[RL_MAINS] = 1'b1;
               end
               nx.phase = PH_IDLE;
            end
            PH_STOP_DLY: begin
               if (!mon) begin
                  nx.relays[RL_GEN] = 1'b0;
                  nx.relays[RL_MAINS] = 1'b0;
                  nx.relays[RL_STOP] = 1'b1;
                  nx.phase = PH_SOLENOID;
                  nx.count = cfg.solenoid_time;
               end else begin
                  nx.phase = PH_IDLE;
               end
            end
            PH_SOLENOID: begin
               nx.relays[RL_STOP] = 1'b0;
               if (st.seq == SQ_STOP) begin
                  nx.phase = PH_CONT_DLY;
                  nx.count = cfg.contactor_delay;
               end else begin
                  nx.phase = PH_IDLE;
               end
            end
            PH_FIXED: begin
               if (st.seq == SQ_POWERUP) begin
                  nx.relays[RL_MAINS] = 1'b1;
                  nx.phase = PH_IDLE;
               end else begin
                  nx.relays[RL_GEN] = 1'b0;
                  nx.relays[RL_MAINS] = 1'b0;
                  nx.relays[RL_STOP] = 1'b1;
                  nx.phase = PH_SOLENOID;
                  nx.count = cfg.solenoid_time;
               end
            end
            default: begin
               nx.phase = PH_IDLE;
            end
         endcase
      end
      return nx;
   endfunction

endpackage

/* hdl/gmts_csr.sv */
// ----------------------------------------------------------------------------
// Transfer sequencer timing registers
// Holds the five delay settings written through the configuration port.
// ----------------------------------------------------------------------------
module gmts_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  logic [2:0]       wr_index,
   input  logic [7:0]       wr_data,
   output gmts_pkg::cfg_type cfg
);

   gmts_pkg::cfg_type cfg_ff;
   gmts_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            gmts_pkg::REG_START_DELAY:     cfg_in.start_delay = wr_data;
            gmts_pkg::REG_STOP_DELAY:      cfg_in.stop_delay = wr_data;
            gmts_pkg::REG_CRANK_TIME:      cfg_in.crank_time = wr_data;
            gmts_pkg::REG_SOLENOID_TIME:   cfg_in.solenoid_time = wr_data;
            gmts_pkg::REG_CONTACTOR_DELAY: cfg_in.contactor_delay = wr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_delay <= gmts_pkg::RST_START_DELAY;
         cfg_ff.stop_delay <= gmts_pkg::RST_STOP_DELAY;
         cfg_ff.crank_time <= gmts_pkg::RST_CRANK_TIME;
         cfg_ff.solenoid_time <= gmts_pkg::RST_SOLENOID_TIME;
         cfg_ff.contactor_delay <= gmts_pkg::RST_CONTACTOR_DELAY;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/gmts_seq.sv */
// ----------------------------------------------------------------------------
// Transfer sequencer state machine
// Applies one item to the sequencer state and settles zero-length phases.
// ----------------------------------------------------------------------------
module gmts_seq #(
   parameter logic [7:0] EMERGENCY_TICKS = 8'd5,
   parameter logic [7:0] POWERUP_TICKS   = 8'd1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step_en,
   input  logic [2:0]          func,
   input  logic                mon,
   input  gmts_pkg::cfg_type   cfg,
   output gmts_pkg::state_type state
);

   gmts_pkg::state_type state_ff;
   gmts_pkg::state_type state_in;

   always_comb begin
      gmts_pkg::state_type st;
      logic busy;
      busy = (state_ff.phase != gmts_pkg::PH_IDLE);
      st = state_ff;
      case (func)
         gmts_pkg::FUNC_TICK: begin
            if (busy) begin
               st.count = 8'(state_ff.count - 8'd1);
            end
         end
         gmts_pkg::FUNC_POWERUP: begin
            if (!busy) begin
               st.relays = 4'd0;
               st.seq = gmts_pkg::SQ_POWERUP;
               st.phase = gmts_pkg::PH_FIXED;
               st.count = POWERUP_TICKS;
            end
         end
         gmts_pkg::FUNC_START: begin
            if (!busy) begin
               st.seq = gmts_pkg::SQ_START;
               st.phase = gmts_pkg::PH_START_DLY;
               st.count = cfg.start_delay;
            end
         end
         gmts_pkg::FUNC_STOP: begin
            if (!busy) begin
               st.seq = gmts_pkg::SQ_STOP;
               st.phase = gmts_pkg::PH_STOP_DLY;
               st.count = cfg.stop_delay;
            end
         end
         gmts_pkg::FUNC_EMERG: begin
            st.seq = gmts_pkg::SQ_EMERG;
            st.phase = gmts_pkg::PH_FIXED;
            st.count = EMERGENCY_TICKS;
         end
         default: ;
      endcase
      for (int i = 0; i < gmts_pkg::SETTLE_STEPS; i++) begin
         st = gmts_pkg::settle_step(st, cfg, mon);
      end
      state_in = step_en ? st : state_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase <= gmts_pkg::PH_IDLE;
         state_ff.seq <= gmts_pkg::SQ_POWERUP;
         state_ff.count <= 8'd0;
         state_ff.relays <= 4'd0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

/* hdl/generator_mains_transfer_sequencer_core.sv */
// ----------------------------------------------------------------------------
// Generator and mains transfer sequencer
// Drives the transfer panel relays from one-second ticks and commands.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_ready  func, monitor_level
//   rsp_      out        rsp_valid / rsp_ready  relay drives, busy, phase
//   csr_      in         csr_valid / csr_ready  index, data
//
// An accepted item sits in the input register while the sequencer update
// runs, and its result is valid once the edge that fires it loads the state
// register, which also serves as the result register. A new item
// is taken every cycle while results are drained. A stalled result holds the
// input stage, and the input stage holds req_ready low once full. Reset is
// synchronous, clears the valid flags and sequencer state and restores the
// delay settings; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "generator_mains_transfer_sequencer_core_assert.svh"

module generator_mains_transfer_sequencer_core #(
   parameter int unsigned EMERGENCY_WAIT = 5,
   parameter int unsigned POWERUP_WAIT   = 1
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_func,
   input  logic       req_monitor_level,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_crank_relay,
   output logic       rsp_solenoid_relay,
   output logic       rsp_gen_contactor,
   output logic       rsp_mains_contactor,
   output logic       rsp_busy_res,
   output logic [2:0] rsp_phase,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [2:0] csr_index,
   input  logic [7:0] csr_data
);

   logic                s1_valid_ff;
   logic                s1_valid_in;
   logic [2:0]          s1_func_ff;
   logic                s1_mon_ff;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic                rsp_free;
   logic                s1_fire;
   logic                count_live;
   logic                sol_ok;
   gmts_pkg::cfg_type   cfg;
   gmts_pkg::state_type state;

   assign csr_ready = 1'b1;

   gmts_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid & csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign s1_fire = s1_valid_ff && rsp_free;
   assign req_ready = !s1_valid_ff || rsp_free;

   assign s1_valid_in = (req_valid && req_ready) || (s1_valid_ff && !rsp_free);
   assign rsp_valid_in = s1_fire || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_func_ff <= req_func;
         s1_mon_ff <= req_monitor_level;
      end
   end

   gmts_seq #(
      .EMERGENCY_TICKS (8'(EMERGENCY_WAIT)),
      .POWERUP_TICKS   (8'(POWERUP_WAIT))
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .step_en (s1_fire),
      .func    (s1_func_ff),
      .mon     (s1_mon_ff),
      .cfg     (cfg),
      .state   (state)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_crank_relay = state.relays[gmts_pkg::RL_START];
   assign rsp_solenoid_relay = state.relays[gmts_pkg::RL_STOP];
   assign rsp_gen_contactor = state.relays[gmts_pkg::RL_GEN];
   assign rsp_mains_contactor = state.relays[gmts_pkg::RL_MAINS];
   assign rsp_busy_res = (state.phase != gmts_pkg::PH_IDLE);
   assign rsp_phase = state.phase;

   assign count_live = (state.phase == gmts_pkg::PH_IDLE) || (state.count != 8'd0);
   assign sol_ok = !state.relays[gmts_pkg::RL_STOP] ||
                   (state.phase == gmts_pkg::PH_SOLENOID) ||
                   (state.phase == gmts_pkg::PH_FIXED);

   `GMTS_ASSERT_SAME(a_count_live, clock, reset, 1'b1, count_live, "Empty countdown.")
   `GMTS_ASSERT_SAME(a_sol_phase, clock, reset, 1'b1, sol_ok, "Solenoid out of phase.")
   `GMTS_ASSERT_NEXT(a_item_to_result, clock, reset, s1_fire, rsp_valid_ff, "Lost result.")

endmodule
